[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge of clk, suspended while rst is high.
`define CABN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cabn assertion failed");
// Checked on every rising edge of clk, also during reset.
`define CABN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cabn assertion failed");
`else
`define CABN_ASSERT(lbl, prop)
`define CABN_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/core/cabn_pkg.sv]
// ----------------------------------------------------------------------------
// cabn_pkg
// Shared types and constants of the class-aware box suppression block.
// ----------------------------------------------------------------------------
package cabn_pkg;

  localparam int FIELD_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 8;
  localparam int THR_W   = 17;
  localparam int DATA_W  = 88;
  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic wr_en;
    logic wr_sel_new;
    logic keep_wr_en;
    logic keep_wr_val;
    logic latch_a;
    logic latch_b;
    logic load_out;
    logic out_last;
    logic set_ovf;
    logic clear_ovf;
  } cabn_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic score_below;
    logic keep_bit;
    logic class_eq;
    logic suppress;
  } cabn_stat_t;

endpackage

[rtl/core/cabn_dp.sv]
// ----------------------------------------------------------------------------
// cabn_dp
// Detection store, keep flags, pipelined overlap test and output register.
// ----------------------------------------------------------------------------
module cabn_dp
  import cabn_pkg::*;
#(
  parameter int MAX_DETS    = 64,
  parameter int COORD_WIDTH = 16,
  parameter int AW          = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  cabn_cmd_t         cmd,
  output cabn_stat_t        stat,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] in_data,
  input  logic              cfg_we,
  input  logic [THR_W-1:0]  cfg_data,
  output logic [DATA_W-1:0] out_data,
  output logic              out_last,
  output logic              out_ovf
);

  localparam int GW  = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int EW  = 4 * GW + SCORE_W + CLASS_W;
  localparam int SO  = 4 * GW;
  localparam int CO  = 4 * GW + SCORE_W;
  localparam int UW  = 2 * GW + 3;
  localparam int UL  = UW / 2;
  localparam int UH  = UW - UL;
  localparam int LW  = THR_W + UW;

  logic [EW-1:0] emem [MAX_DETS];
  logic          kmem [MAX_DETS];
  logic [EW-1:0] ent_q;
  logic          keep_q;
  logic [EW-1:0] new_ent;
  logic [EW-1:0] a_ent;
  logic [EW-1:0] b_ent;
  logic [THR_W-1:0] thr;
  logic          ovf;

  logic [GW+1:0]   iw, ih;
  logic [2*GW-1:0] area_a, area_b;
  logic [2*GW+3:0] inter2, inter3, inter4;
  logic [UW-1:0]   asum2, uni3;
  logic [THR_W+UL-1:0] p_lo;
  logic [THR_W+UH-1:0] p_hi;
  logic            uz4;
  logic [LW-1:0]   lhs, rhs;

  // Doubled overlap of two spans given as center and size.
  function automatic logic [GW+1:0] span(input logic [GW-1:0] ca, input logic [GW-1:0] sa,
                                         input logic [GW-1:0] cb, input logic [GW-1:0] sb);
    logic signed [GW+2:0] a1, a2, b1, b2, lo, hi, d;
    a1 = $signed({2'b00, ca, 1'b0}) - $signed({3'b000, sa});
    a2 = $signed({2'b00, ca, 1'b0}) + $signed({3'b000, sa});
    b1 = $signed({2'b00, cb, 1'b0}) - $signed({3'b000, sb});
    b2 = $signed({2'b00, cb, 1'b0}) + $signed({3'b000, sb});
    lo = (a1 > b1) ? a1 : b1;
    hi = (a2 < b2) ? a2 : b2;
    d  = hi - lo;
    return (hi > lo) ? d[GW+1:0] : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      new_ent <= {in_data[87:80], in_data[79:64], in_data[48 +: GW], in_data[32 +: GW],
                  in_data[16 +: GW], in_data[0 +: GW]};
    end
    if (cmd.wr_en) begin
      emem[wr_addr] <= cmd.wr_sel_new ? new_ent : ent_q;
    end
    if (cmd.keep_wr_en) begin
      kmem[wr_addr] <= cmd.keep_wr_val;
    end
    if (cmd.rd_en) begin
      ent_q  <= emem[rd_addr];
      keep_q <= kmem[rd_addr];
    end
    if (cmd.latch_a) begin
      a_ent <= ent_q;
    end
    if (cmd.latch_b) begin
      b_ent <= ent_q;
    end
    if (cmd.load_out) begin
      out_data <= {ent_q[EW-1:CO], ent_q[CO-1:SO], FIELD_W'(ent_q[4*GW-1:3*GW]),
                   FIELD_W'(ent_q[3*GW-1:2*GW]), FIELD_W'(ent_q[2*GW-1:GW]),
                   FIELD_W'(ent_q[GW-1:0])};
      out_last <= cmd.out_last;
      out_ovf  <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      ovf <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end else if (cmd.clear_ovf) begin
        ovf <= 1'b0;
      end
    end
  end

  // Overlap test pipeline: spans and areas, intersection, union, threshold products.
  always_ff @(posedge clk) begin
    iw     <= span(a_ent[GW-1:0], a_ent[3*GW-1:2*GW], b_ent[GW-1:0], b_ent[3*GW-1:2*GW]);
    ih     <= span(a_ent[2*GW-1:GW], a_ent[4*GW-1:3*GW], b_ent[2*GW-1:GW],
                   b_ent[4*GW-1:3*GW]);
    area_a <= a_ent[3*GW-1:2*GW] * a_ent[4*GW-1:3*GW];
    area_b <= b_ent[3*GW-1:2*GW] * b_ent[4*GW-1:3*GW];
    inter2 <= iw * ih;
    asum2  <= {1'b0, area_a, 2'b00} + {1'b0, area_b, 2'b00};
    inter3 <= inter2;
    uni3   <= asum2 - inter2[UW-1:0];
    inter4 <= inter3;
    p_lo   <= thr * uni3[UL-1:0];
    p_hi   <= thr * uni3[UW-1:UL];
    uz4    <= (uni3 == '0);
  end

  assign lhs = {inter4, 16'h0000};
  assign rhs = {p_hi, {UL{1'b0}}} + {{UH{1'b0}}, p_lo};

  assign stat.score_below = ent_q[CO-1:SO] < new_ent[CO-1:SO];
  assign stat.keep_bit    = keep_q;
  assign stat.class_eq    = ent_q[EW-1:CO] == a_ent[EW-1:CO];
  assign stat.suppress    = !uz4 && (lhs > rhs);

endmodule

[rtl/core/cabn_ctrl.sv]
// ----------------------------------------------------------------------------
// cabn_ctrl
// Sequencer for ordered insertion, greedy suppression and emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cabn_ctrl
  import cabn_pkg::*;
#(
  parameter int MAX_DETS = 64,
  parameter int AW       = 6,
  parameter int CNTW     = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output cabn_cmd_t     cmd,
  input  cabn_stat_t    stat,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR, S_SUP_I, S_SUP_IA, S_SUP_J, S_SUP_JB,
    S_IOU, S_DEC, S_SCAN_RD, S_SCAN_CHK, S_EMIT_RD, S_EMIT_CHK, S_EMIT_WAIT
  } state_t;

  localparam logic [CNTW-1:0] FULL = CNTW'(MAX_DETS);

  state_t          state;
  logic [CNTW-1:0] count, i, j, p, last_idx;
  logic [CNTW-1:0] pm1;
  logic            item_last;
  logic [1:0]      wait_cnt;

  assign pm1      = p - 1'b1;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd     = '0;
    rd_addr = i[AW-1:0];
    wr_addr = p[AW-1:0];
    unique case (state)
      S_IDLE: begin
        cmd.load_item = in_valid;
        cmd.set_ovf   = in_valid && (count == FULL);
      end
      S_INS_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = pm1[AW-1:0];
      end
      S_INS_CMP: begin
        cmd.wr_en       = stat.score_below;
        cmd.keep_wr_en  = stat.score_below;
        cmd.keep_wr_val = 1'b1;
      end
      S_INS_WR: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel_new  = 1'b1;
        cmd.keep_wr_en  = 1'b1;
        cmd.keep_wr_val = 1'b1;
      end
      S_SUP_I:  cmd.rd_en = (i != count);
      S_SUP_IA: cmd.latch_a = 1'b1;
      S_SUP_J: begin
        cmd.rd_en = (j != count);
        rd_addr   = j[AW-1:0];
      end
      S_SUP_JB: cmd.latch_b = 1'b1;
      S_IOU: begin
      end
      S_DEC: begin
        cmd.keep_wr_en = stat.suppress;
        wr_addr        = j[AW-1:0];
      end
      S_SCAN_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = p[AW-1:0];
      end
      S_SCAN_CHK: begin
      end
      S_EMIT_RD: begin
        cmd.rd_en     = (i != count);
        cmd.clear_ovf = (i == count);
      end
      S_EMIT_CHK: begin
        cmd.load_out = stat.keep_bit;
        cmd.out_last = (i == last_idx);
      end
      S_EMIT_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_last <= in_last;
            if (count != FULL) begin
              p     <= count;
              state <= (count == '0) ? S_INS_WR : S_INS_RD;
            end else if (in_last) begin
              i     <= '0;
              state <= S_SUP_I;
            end
          end
        end
        S_INS_RD: state <= S_INS_CMP;
        S_INS_CMP: begin
          if (stat.score_below) begin
            p     <= pm1;
            state <= (pm1 == '0) ? S_INS_WR : S_INS_RD;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          count <= count + 1'b1;
          i     <= '0;
          state <= item_last ? S_SUP_I : S_IDLE;
        end
        S_SUP_I: begin
          if (i == count) begin
            p     <= count - 1'b1;
            state <= S_SCAN_RD;
          end else begin
            state <= S_SUP_IA;
          end
        end
        S_SUP_IA: begin
          if (stat.keep_bit) begin
            j     <= i + 1'b1;
            state <= S_SUP_J;
          end else begin
            i     <= i + 1'b1;
            state <= S_SUP_I;
          end
        end
        S_SUP_J: begin
          if (j == count) begin
            i     <= i + 1'b1;
            state <= S_SUP_I;
          end else begin
            state <= S_SUP_JB;
          end
        end
        S_SUP_JB: begin
          if (stat.keep_bit && stat.class_eq) begin
            wait_cnt <= '0;
            state    <= S_IOU;
          end else begin
            j     <= j + 1'b1;
            state <= S_SUP_J;
          end
        end
        S_IOU: begin
          wait_cnt <= wait_cnt + 1'b1;
          if (wait_cnt == 2'd3) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          j     <= j + 1'b1;
          state <= S_SUP_J;
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (stat.keep_bit) begin
            last_idx <= p;
            i        <= '0;
            state    <= S_EMIT_RD;
          end else begin
            p     <= pm1;
            state <= S_SCAN_RD;
          end
        end
        S_EMIT_RD: begin
          if (i == count) begin
            count <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_EMIT_CHK;
          end
        end
        S_EMIT_CHK: begin
          if (stat.keep_bit) begin
            out_valid <= 1'b1;
            state     <= S_EMIT_WAIT;
          end else begin
            i     <= i + 1'b1;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            i         <= i + 1'b1;
            state     <= S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CABN_ASSERT(a_count_cap, count <= FULL)
  `CABN_ASSERT(a_valid_only_emit, out_valid |-> state == S_EMIT_WAIT)
  `CABN_ASSERT(a_j_after_i, (state == S_SUP_JB) |-> (j > i && j < count))
  `CABN_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid)

endmodule

[rtl/core/class_aware_box_nms.sv]
// ----------------------------------------------------------------------------
// class_aware_box_nms
// Class-aware greedy non-maximum suppression over one batch of boxes.
// ----------------------------------------------------------------------------
// Boxes arrive one beat at a time and are inserted into a store with one
// read and one write port, kept in descending score order, equal scores in
// arrival order. Insertion walks down from the end of the store, reading and
// comparing one stored entry at a time and moving each entry of lower score
// up by one place; the first box of a batch is written straight in, and a
// dropped box is taken and discarded. The beat with tlast closes the batch,
// and greedy suppression then pairs every still-kept box with each later box:
// a pair is rejected for a cleared keep flag or another class, and any other
// pair goes through the four-stage overlap test, all paced by the one store
// read port. A backward scan finds the last kept box, and the kept boxes are
// then sent one beat at a time, each held through any output stall, with
// every suppressed entry skipped on the way. The store holds MAX_DETS boxes;
// further boxes of the batch are dropped and every result beat of that
// batch carries the overflow flag in tuser. No input is taken from the
// moment a batch closes until its last result beat leaves.
// The overlap threshold is to be written through cfg_wr_en only while the
// block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module class_aware_box_nms
  import cabn_pkg::*;
#(
  parameter int MAX_DETS    = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wr_data,      // overlap_threshold, Q1.16
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // box_center_x, box_center_y, box_width, box_height, box_score, box_class
  input  logic [DATA_W-1:0] s_axis_tdata,
  input  logic              s_axis_tlast,     // batch_last
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // kept_center_x, kept_center_y, kept_width, kept_height, kept_score, kept_class
  output logic [DATA_W-1:0] m_axis_tdata,
  output logic              m_axis_tlast,     // kept_last
  output logic [0:0]        m_axis_tuser      // batch_overflow
);

  localparam int AW   = $clog2(MAX_DETS);
  localparam int CNTW = $clog2(MAX_DETS + 1);

  cabn_cmd_t     cmd;
  cabn_stat_t    stat;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // The sequencer owns the handshakes, indices and batch count.
  cabn_ctrl #(
    .MAX_DETS(MAX_DETS),
    .AW      (AW),
    .CNTW    (CNTW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .cmd      (cmd),
    .stat     (stat),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  // The datapath holds the store, the threshold and the overlap arithmetic.
  cabn_dp #(
    .MAX_DETS   (MAX_DETS),
    .COORD_WIDTH(COORD_WIDTH),
    .AW         (AW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .in_data (s_axis_tdata),
    .cfg_we  (cfg_wr_en),
    .cfg_data(cfg_wr_data),
    .out_data(m_axis_tdata),
    .out_last(m_axis_tlast),
    .out_ovf (m_axis_tuser[0])
  );

endmodule

[verif/nms_checker.sv]
// ----------------------------------------------------------------------------
// nms_checker
// Watches both stream channels of the box suppression block, predicts the
// kept boxes of every closed batch and compares each output beat with them.
// ----------------------------------------------------------------------------
module nms_checker
  import cabn_pkg::*;
#(
  parameter int MAX_DETS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [THR_W-1:0]  cfg_wr_data,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [DATA_W-1:0] m_axis_tdata,
  input  logic              m_axis_tlast,
  input  logic [0:0]        m_axis_tuser,
  output int                failures,
  output int                pending
);

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    logic [FIELD_W-1:0] h;
    logic [FIELD_W-1:0] w;
    logic [FIELD_W-1:0] cy;
    logic [FIELD_W-1:0] cx;
  } box_t;

  typedef struct packed {
    box_t box;
    logic last;
    logic ovf;
  } kept_t;

  box_t             ranked_boxes [MAX_DETS];
  bit               still_kept   [MAX_DETS];
  int               box_count;
  bit               dropped_any;
  logic [THR_W-1:0] overlap_thr;
  kept_t            kept_queue [$];

  assign pending = kept_queue.size();

  // Doubled corners keep half-pixel edges exact.
  function automatic longint span_common(input longint ca, sa, cb, sb);
    longint lo, hi;
    lo = (2*ca - sa > 2*cb - sb) ? 2*ca - sa : 2*cb - sb;
    hi = (2*ca + sa < 2*cb + sb) ? 2*ca + sa : 2*cb + sb;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic bit too_close(input box_t a, input box_t b, input logic [THR_W-1:0] t);
    longint unsigned inter, uni;
    inter = span_common(a.cx, a.w, b.cx, b.w) * span_common(a.cy, a.h, b.cy, b.h);
    uni = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h) - inter;
    if (uni == 0) return 0;
    return (inter * 65536) > (longint'(t) * uni);
  endfunction

  task automatic close_batch();
    int last_idx;
    kept_t k;
    for (int i = 0; i < box_count; i++) begin
      if (!still_kept[i]) continue;
      for (int j = i + 1; j < box_count; j++)
        if (still_kept[j] && ranked_boxes[i].cls == ranked_boxes[j].cls &&
            too_close(ranked_boxes[i], ranked_boxes[j], overlap_thr))
          still_kept[j] = 0;
    end
    last_idx = 0;
    for (int i = 0; i < box_count; i++) if (still_kept[i]) last_idx = i;
    for (int i = 0; i < box_count; i++) begin
      if (!still_kept[i]) continue;
      k.box  = ranked_boxes[i];
      k.last = (i == last_idx);
      k.ovf  = dropped_any;
      kept_queue = {kept_queue, k};
    end
    for (int i = 0; i < MAX_DETS; i++) still_kept[i] = 1;
    box_count   = 0;
    dropped_any = 0;
  endtask

  task automatic insert_box(input box_t b);
    int pos;
    pos = box_count;
    while (pos > 0 && ranked_boxes[pos-1].score < b.score) pos--;
    for (int i = box_count; i > pos; i--) ranked_boxes[i] = ranked_boxes[i-1];
    ranked_boxes[pos] = b;
    box_count++;
  endtask

  initial begin
    failures = 0;
    box_count = 0;
    dropped_any = 0;
    overlap_thr = THR_RESET;
    for (int i = 0; i < MAX_DETS; i++) still_kept[i] = 1;
  end

  always @(posedge clk) begin
    kept_t exp_k, got_k;
    if (rst) begin
      overlap_thr = THR_RESET;
      box_count = 0;
      dropped_any = 0;
      kept_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_k.box  = m_axis_tdata;
        got_k.last = m_axis_tlast;
        got_k.ovf  = m_axis_tuser[0];
        if (kept_queue.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected output beat %h", got_k);
        end else begin
          exp_k = kept_queue.pop_front();
          if (got_k !== exp_k) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected box %h last %b ovf %b, got box %h last %b ovf %b",
                       exp_k.box, exp_k.last, exp_k.ovf, got_k.box, got_k.last, got_k.ovf);
          end
        end
      end
      if (cfg_wr_en) overlap_thr = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        if (box_count < MAX_DETS) insert_box(s_axis_tdata);
        else dropped_any = 1;
        if (s_axis_tlast) close_batch();
      end
    end
  end

endmodule

[verif/tb_class_aware_box_nms.sv]
// ----------------------------------------------------------------------------
// tb_class_aware_box_nms
// Stimulus and verdict for the class-aware box suppression block.
// ----------------------------------------------------------------------------
// Batches of boxes are streamed in, first a few hand-made ones covering
// suppression, class separation, score ties, zero-area boxes and threshold
// extremes, then random batches built around clusters of boxes so that real
// overlaps occur. The checker instance predicts every kept box; this module
// only drives beats, rewrites the threshold between batches and decides.
// ----------------------------------------------------------------------------
module tb_class_aware_box_nms;
  import cabn_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [THR_W-1:0]  cfg_wr_data;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // box_center_x, box_center_y, box_width, box_height, box_score, box_class
  logic [DATA_W-1:0] s_axis_tdata;
  logic              s_axis_tlast;   // batch_last
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // kept_center_x, kept_center_y, kept_width, kept_height, kept_score, kept_class
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;   // kept_last
  logic [0:0]        m_axis_tuser;   // batch_overflow

  int     failures;
  int     pending;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     boxes_sent;
  longint cycles;

  class_aware_box_nms dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  nms_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The watchdog covers the worst case of full batches whose quadratic
  // suppression pass runs behind a heavily stalled output.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver throttles itself at random; the rate follows the phase.
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic logic [DATA_W-1:0] pack_box(input int cx, cy, w, h, score, cls);
    return {cls[7:0], score[15:0], h[15:0], w[15:0], cy[15:0], cx[15:0]};
  endfunction

  // Sends one beat, with random sender gaps in front of it.
  task automatic send_beat(input logic [DATA_W-1:0] d, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    boxes_sent++;
  endtask

  // The threshold only changes once the previous batch has fully drained.
  task automatic write_threshold(input logic [THR_W-1:0] t);
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en   <= 1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  // A random batch: mostly boxes jittered around one spot so they overlap,
  // a few drawn over the whole field range.
  task automatic send_random_batch(input int n);
    int bx, by, bw, bh, score, cls, prev_score;
    bx = $urandom_range(65535);
    by = $urandom_range(65535);
    bw = $urandom_range(4000, 1);
    bh = $urandom_range(4000, 1);
    prev_score = $urandom_range(65535);
    for (int i = 0; i < n; i++) begin
      score = ($urandom_range(99) < 15) ? prev_score : $urandom_range(65535);
      cls   = ($urandom_range(99) < 80) ? $urandom_range(2) : $urandom_range(255);
      if ($urandom_range(99) < 75)
        send_beat(pack_box((bx + $urandom_range(bw)) & 16'hFFFF,
                           (by + $urandom_range(bh)) & 16'hFFFF,
                           bw + $urandom_range(bw/2), bh + $urandom_range(bh/2),
                           score, cls), i == n - 1);
      else
        send_beat(pack_box($urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535),
                           score, cls), i == n - 1);
      prev_score = score;
    end
  endtask

  initial begin
    int thr_choices[4];
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    m_axis_tready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    boxes_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Reset threshold of one half: a higher-scored near-duplicate suppresses,
    // another class and a distant tie survive, and a zero-area box never
    // suppresses. Field extremes close the batch.
    send_beat(pack_box(1000, 1000, 200, 200, 50000, 3), 0);
    send_beat(pack_box(1010, 1005, 200, 200, 60000, 3), 0);
    send_beat(pack_box(1000, 1000, 200, 200, 50000, 4), 0);
    send_beat(pack_box(9000, 9000, 200, 200, 50000, 3), 0);
    send_beat(pack_box(1010, 1005, 0, 0, 65535, 3), 0);
    send_beat(pack_box(65535, 65535, 65535, 65535, 0, 255), 0);
    send_beat(pack_box(0, 0, 0, 0, 0, 0), 1);

    // Threshold zero: any positive overlap suppresses, zero-area pairs do not.
    write_threshold(THR_W'(0));
    send_beat(pack_box(100, 100, 20, 20, 900, 7), 0);
    send_beat(pack_box(119, 119, 20, 20, 800, 7), 0);
    send_beat(pack_box(500, 500, 0, 10, 700, 7), 0);
    send_beat(pack_box(500, 500, 0, 10, 600, 7), 1);

    // Threshold of one: identical boxes all survive.
    write_threshold(THR_W'(65536));
    send_beat(pack_box(300, 300, 50, 50, 10, 1), 0);
    send_beat(pack_box(300, 300, 50, 50, 10, 1), 0);
    send_beat(pack_box(300, 300, 50, 50, 10, 1), 1);

    // A single-box batch.
    send_beat(pack_box(1234, 4321, 77, 88, 65535, 128), 1);

    // Random phases: no idling, sender gaps, receiver stalls, both.
    thr_choices = '{65535, 32768, 0, 0};
    for (int phase = 0; phase < 4; phase++) begin
      int phase_start;
      send_idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 24 : 0;
      recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 24 : 0;
      write_threshold(THR_W'((phase == 3) ? $urandom_range(65535) : thr_choices[phase]));
      phase_start = boxes_sent;
      // One batch longer than the store, its tlast on a dropped box.
      if (phase == 1) send_random_batch(66);
      while (boxes_sent - phase_start < 40)
        send_random_batch(($urandom_range(99) < 20) ? 1 : $urandom_range(12, 2));
    end

    @(negedge clk);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cabn_pkg.sv
rtl/core/cabn_dp.sv
rtl/core/cabn_ctrl.sv
rtl/core/class_aware_box_nms.sv
verif/nms_checker.sv
verif/tb_class_aware_box_nms.sv
